[hdl/mts_pkg.sv]
`timescale 1ns / 1ps
package mts_pkg;

	// Data width of one stack entry
	localparam int unsigned MTS_WIDTH         = 32;
	// Default number of entries
	localparam int unsigned MTS_DEPTH_DEFAULT = 64;

	// Command codes carried in s_tuser
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		MTS_OK    = 2'd0,
		MTS_FULL  = 2'd1,
		MTS_EMPTY = 2'd2
	} mts_status_t;

	// Shift control for a row of cells
	typedef struct packed {
		logic push;
		logic pop;
	} mts_shift_t;

endpackage

[hdl/mts_cell.sv]
`timescale 1ns / 1ps
module mts_cell (
	input  logic                               clk,
	input  mts_pkg::mts_shift_t                shift,
	input  logic [mts_pkg::MTS_WIDTH-1:0]      from_above,
	input  logic [mts_pkg::MTS_WIDTH-1:0]      from_below,
	output logic [mts_pkg::MTS_WIDTH-1:0]      data
);
	import mts_pkg::*;

	logic [MTS_WIDTH-1:0] data_q;

	// Take the upper neighbor on push, the lower one on pop, hold otherwise
	always_ff @(posedge clk) begin
		if (shift.push) begin
			data_q <= from_above;
		end else if (shift.pop) begin
			data_q <= from_below;
		end
	end

	assign data = data_q;

endmodule

[hdl/mts_chain.sv]
`timescale 1ns / 1ps
module mts_chain #(
	parameter int unsigned STACK_DEPTH = mts_pkg::MTS_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  mts_pkg::mts_shift_t                shift,
	input  logic [mts_pkg::MTS_WIDTH-1:0]      push_data,
	output logic [mts_pkg::MTS_WIDTH-1:0]      head,
	output logic [mts_pkg::MTS_WIDTH-1:0]      second
);
	import mts_pkg::*;

	logic [MTS_WIDTH-1:0] cell_data [STACK_DEPTH];

	// Build the row: cell 0 is the top, each cell talks to its neighbors
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [MTS_WIDTH-1:0] above;
		logic [MTS_WIDTH-1:0] below;

		if (i == 0) begin : g_first
			assign above = push_data;
		end else begin : g_mid
			assign above = cell_data[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_inner
			assign below = cell_data[i+1];
		end

		mts_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_above (above),
			.from_below (below),
			.data       (cell_data[i])
		);
	end

	assign head   = cell_data[0];
	assign second = cell_data[1];

endmodule

[hdl/min_tracking_stack.sv]
`timescale 1ns / 1ps
// Stack of signed 32-bit values that also reports its running minimum.
// Input channel (s_*): one command per transaction. s_tuser selects push
// or pop, s_tdata carries the value to push (ignored on pop).
// Output channel (m_*): one result per command, giving the new top, the
// new minimum, an empty flag and a status (ok, push refused because full,
// pop refused because empty). A refused command leaves the stack as it is.
// The result appears on m_tvalid in the cycle after the command is
// accepted. One command per cycle while the receiver takes results; every entry
// of the value row and of the minimum row shifts by one cell at once, so depth
// does not affect the rate.
// Reset clears the fill counts and the output valid; cell contents are not
// cleared and are never shown before being written.
// When the receiver stalls, the result holds in the output register and
// s_tready drops until it is taken; a new command is taken in the same cycle
// that the pending result leaves.
module min_tracking_stack #(
	parameter int unsigned STACK_DEPTH = mts_pkg::MTS_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [31:0] top_value, [63:32] min_value,
	                               // [64] is_empty, [66:65] status, [71:67] zero
);
	import mts_pkg::*;

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [CW-1:0]        vcnt_q, mcnt_q, vcnt_n, mcnt_n;
	logic                 out_valid_q;
	logic [MTS_WIDTH-1:0] top_q, min_q, top_n, min_n;
	logic                 empty_q;
	mts_status_t          status_q, status_n;

	logic                 accept, is_pop, full, empty;
	logic                 push_ok, pop_ok, min_push, min_pop;
	logic [MTS_WIDTH-1:0] val;
	logic [MTS_WIDTH-1:0] val_head, val_second, min_head, min_second;
	mts_shift_t           val_shift, min_shift;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_pop   = (s_tuser[0] == CMD_POP);
	assign val      = s_tdata;
	assign full     = (vcnt_q == CW'(STACK_DEPTH));
	assign empty    = (vcnt_q == '0);

	// Decide which rows move
	always_comb begin
		push_ok  = accept && !is_pop && !full;
		pop_ok   = accept && is_pop && !empty;
		min_push = push_ok && ((mcnt_q == '0) || ($signed(val) <= $signed(min_head)));
		min_pop  = pop_ok && (mcnt_q != '0) && (min_head == val_head);
		val_shift.push = push_ok;
		val_shift.pop  = pop_ok;
		min_shift.push = min_push;
		min_shift.pop  = min_pop;
	end

	mts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_val_chain (
		.clk       (clk),
		.shift     (val_shift),
		.push_data (val),
		.head      (val_head),
		.second    (val_second)
	);

	mts_chain #(.STACK_DEPTH(STACK_DEPTH)) u_min_chain (
		.clk       (clk),
		.shift     (min_shift),
		.push_data (val),
		.head      (min_head),
		.second    (min_second)
	);

	// Form the counts and result after this command
	always_comb begin
		vcnt_n = vcnt_q;
		mcnt_n = mcnt_q;
		if (push_ok) begin
			vcnt_n = vcnt_q + CW'(1);
		end else if (pop_ok) begin
			vcnt_n = vcnt_q - CW'(1);
		end
		if (min_push) begin
			mcnt_n = mcnt_q + CW'(1);
		end else if (min_pop) begin
			mcnt_n = mcnt_q - CW'(1);
		end

		status_n = MTS_OK;
		if (accept && !is_pop && full) begin
			status_n = MTS_FULL;
		end else if (accept && is_pop && empty) begin
			status_n = MTS_EMPTY;
		end

		if (vcnt_n == '0) begin
			top_n = '0;
		end else if (push_ok) begin
			top_n = val;
		end else if (pop_ok) begin
			top_n = val_second;
		end else begin
			top_n = val_head;
		end

		if (vcnt_n == '0 || mcnt_n == '0) begin
			min_n = '0;
		end else if (min_push) begin
			min_n = val;
		end else if (min_pop) begin
			min_n = min_second;
		end else begin
			min_n = min_head;
		end
	end

	// Hold counts and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vcnt_q <= vcnt_n;
			mcnt_q <= mcnt_n;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result register on each accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			top_q    <= top_n;
			min_q    <= min_n;
			empty_q  <= (vcnt_n == '0);
			status_q <= status_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, status_q, empty_q, min_q, top_q};

`ifndef SYNTHESIS
	a_min_le_val: assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q <= vcnt_q)
		else $error("minimum count exceeds value count");

	a_min_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(vcnt_q != '0) |-> (mcnt_q != '0))
		else $error("minimum row empty while values held");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CW'(STACK_DEPTH))
		else $error("value count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_pop && !full) |=> (vcnt_q == $past(vcnt_q) + CW'(1)))
		else $error("accepted push did not grow the stack");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (empty_q == (vcnt_q == '0)))
		else $error("pending empty flag disagrees with count");
`endif

endmodule

[tb/sv/min_tracking_stack_test.sv]
`timescale 1ns / 1ps
module min_tracking_stack_test;
	import mts_pkg::*;

	localparam int DEPTH        = MTS_DEPTH_DEFAULT;
	localparam int TOTAL_CMDS   = 1375;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int REPORT_LIMIT = 100;

	typedef struct packed {
		logic              cmd;
		logic signed [31:0] value;
	} stack_cmd_t;

	typedef struct packed {
		logic signed [31:0] top;
		logic signed [31:0] minimum;
		logic               is_empty;
		mts_status_t        status;
	} stack_view_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] value
	logic [0:0]  s_tuser  = '0;   // [0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;          // [31:0] top, [63:32] min, [64] empty, [66:65] status

	stack_cmd_t  pending_cmds[$];
	stack_view_t expected_views[$];

	// Shadow copy of the value and minimum stacks
	logic signed [31:0] shadow_vals[DEPTH];
	logic signed [31:0] shadow_mins[DEPTH];
	int                 shadow_fill = 0;
	int                 shadow_min_fill = 0;

	// Fill level seen by the command generator
	int                 gen_fill = 0;
	logic [31:0]        gen_last = '0;

	int send_gap = 0, send_quiet = 0;
	int take_gap = 0, take_quiet = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	min_tracking_stack #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5ns clk = ~clk;

	// Mostly short gaps, a few long ones, and now and then a quiet stretch
	function automatic int pick_gap(inout int quiet);
		int r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Apply one command to the shadow stacks and return the view after it
	function automatic stack_view_t apply_stack_cmd(logic cmd, logic signed [31:0] value);
		stack_view_t v;
		v.status = MTS_OK;
		if (cmd == CMD_PUSH) begin
			if (shadow_fill >= DEPTH) begin
				v.status = MTS_FULL;
			end else begin
				if (shadow_min_fill == 0 || value <= shadow_mins[shadow_min_fill - 1]) begin
					shadow_mins[shadow_min_fill] = value;
					shadow_min_fill++;
				end
				shadow_vals[shadow_fill] = value;
				shadow_fill++;
			end
		end else begin
			if (shadow_fill == 0) begin
				v.status = MTS_EMPTY;
			end else begin
				// drop the minimum too when it is the value leaving
				if (shadow_min_fill > 0 &&
				    shadow_mins[shadow_min_fill - 1] == shadow_vals[shadow_fill - 1])
					shadow_min_fill--;
				shadow_fill--;
			end
		end
		v.is_empty = (shadow_fill == 0);
		v.top      = v.is_empty ? '0 : shadow_vals[shadow_fill - 1];
		v.minimum  = (!v.is_empty && shadow_min_fill > 0) ? shadow_mins[shadow_min_fill - 1] : '0;
		return v;
	endfunction

	task automatic add_cmd(logic cmd, logic [31:0] value);
		stack_cmd_t c;
		c.cmd   = cmd;
		c.value = value;
		pending_cmds.push_back(c);
		if (cmd == CMD_PUSH) begin
			if (gen_fill < DEPTH)
				gen_fill++;
			gen_last = value;
		end else if (gen_fill > 0) begin
			gen_fill--;
		end
	endtask

	// Mix of wide random values, small ones that collide, extremes and near repeats
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return $urandom;
		if (r < 7)
			return 32'($signed($urandom_range(0, 8)) - 4);
		if (r == 7) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'hffff_ffff;
				default: return 32'h0000_0000;
			endcase
		end
		return gen_last + 32'($signed($urandom_range(0, 4)) - 2);
	endfunction

	task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
	endtask

	// Drive commands from the pending queue, holding each until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				void'(pending_cmds.pop_front());
				send_gap = pick_gap(send_quiet);
			end
			if (s_tvalid && !s_tready) begin
				// hold the current transaction
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				s_tvalid   <= 1'b1;
				s_tdata    <= pending_cmds[0].value;
				s_tuser[0] <= pending_cmds[0].cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Check results against the oldest expectation, then predict new ones
	always @(posedge clk) begin
		stack_view_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_views.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: unexpected result, expected none, actual %h",
						         $time, m_tdata);
				end else begin
					want = expected_views.pop_front();
					if (m_tdata[31:0] !== want.top)
						report_mismatch("top_value", want.top, m_tdata[31:0]);
					if (m_tdata[63:32] !== want.minimum)
						report_mismatch("min_value", want.minimum, m_tdata[63:32]);
					if (m_tdata[64] !== want.is_empty)
						report_mismatch("is_empty", 32'(want.is_empty), 32'(m_tdata[64]));
					if (m_tdata[66:65] !== want.status)
						report_mismatch("status", 32'(want.status), 32'(m_tdata[66:65]));
				end
				take_gap = pick_gap(take_quiet);
			end
			if (s_tvalid && s_tready)
				expected_views.push_back(apply_stack_cmd(s_tuser[0], s_tdata));
			if (take_gap > 0) begin
				take_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int  n;
		bit  falling;
		logic [31:0] v;

		// Directed: pop when empty, extremes, equal minimums, value ignored on pop
		add_cmd(CMD_POP,  32'h1234_5678);
		add_cmd(CMD_PUSH, 32'h7fff_ffff);
		add_cmd(CMD_PUSH, 32'h0000_0000);
		add_cmd(CMD_PUSH, 32'h8000_0000);
		add_cmd(CMD_PUSH, 32'h8000_0000);
		add_cmd(CMD_PUSH, 32'hffff_ffff);
		add_cmd(CMD_PUSH, 32'h8000_0001);
		add_cmd(CMD_POP,  32'hffff_ffff);
		add_cmd(CMD_POP,  32'h8000_0000);
		add_cmd(CMD_POP,  32'h0000_0000);
		add_cmd(CMD_POP,  32'h0000_0000);
		add_cmd(CMD_PUSH, 32'h0000_0001);
		add_cmd(CMD_PUSH, 32'h0000_0000);
		add_cmd(CMD_POP,  32'h0000_0000);
		add_cmd(CMD_POP,  32'h0000_0000);
		add_cmd(CMD_POP,  32'h0000_0000);
		add_cmd(CMD_POP,  32'h0000_0000);
		add_cmd(CMD_POP,  32'hdead_beef);
		add_cmd(CMD_PUSH, 32'h5555_5555);
		add_cmd(CMD_PUSH, 32'haaaa_aaaa);
		add_cmd(CMD_POP,  32'h5555_5555);
		add_cmd(CMD_POP,  32'haaaa_aaaa);

		// Random: fill to or past full, drain to or past empty, mixed and noisy runs
		while (pending_cmds.size() < TOTAL_CMDS) begin
			case ($urandom_range(0, 3))
				0: begin
					n       = DEPTH - gen_fill + $urandom_range(0, 3);
					falling = $urandom_range(0, 1);
					repeat (n) begin
						v = falling ? gen_last - $urandom_range(0, 2) : pick_value();
						add_cmd(CMD_PUSH, v);
					end
				end
				1: begin
					n = gen_fill + $urandom_range(0, 3);
					repeat (n)
						add_cmd(CMD_POP, $urandom);
				end
				2: begin
					n = $urandom_range(10, 40);
					repeat (n) begin
						if ($urandom_range(0, 9) < 6)
							add_cmd(CMD_PUSH, pick_value());
						else
							add_cmd(CMD_POP, $urandom);
					end
				end
				default: begin
					n = $urandom_range(5, 20);
					repeat (n) begin
						if ($urandom_range(0, 1) == 0)
							add_cmd(CMD_PUSH, pick_value());
						else
							add_cmd(CMD_POP, $urandom);
					end
				end
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for every command to go in and every result to come out
		while (pending_cmds.size() != 0 || s_tvalid || expected_views.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatch_count == 0 && expected_views.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
hdl/mts_pkg.sv
hdl/mts_cell.sv
hdl/mts_chain.sv
hdl/min_tracking_stack.sv
tb/sv/min_tracking_stack_test.sv
